FILE: hdl/rpvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpvr_pkg
// Types and constants shared by the ramped PI voltage regulator files.
// ----------------------------------------------------------------------------
package rpvr_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_ERROR_ABS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_COUNT_LIMIT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_POINTS      = 3'd7;

    localparam int CFG_DATA_W = 32;

    // item function codes
    localparam logic FUNC_REGULATE = 1'b0;
    localparam logic FUNC_STOP     = 1'b1;

    // input item
    typedef struct packed {
        logic        func;
        logic [31:0] measured_voltage;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [31:0] drive_voltage;
        logic        drive_valid;
        logic        pulse_done;
        logic        following_fault;
    } t_out_item;

    // configuration registers
    typedef struct packed {
        logic [30:0] setpoint;
        logic [30:0] ramp_step;
        logic [31:0] prop_gain;
        logic [31:0] integ_gain;
        logic [30:0] allowed_error_abs;
        logic [15:0] integ_limit;
        logic [15:0] fault_count_limit;
        logic [15:0] pulse_points;
    } t_cfg;

    // regulator loop state
    typedef struct packed {
        logic [30:0] target_voltage;
        logic [31:0] integrator;
        logic [15:0] sample_count;
        logic [15:0] following_count;
    } t_state;

endpackage

FILE: hdl/rpvr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpvr_step
// One regulator sample: ramp the target, form the error, update the
// integrator or following-error counter and compute the clamped drive, or clear the state on a stop item.
// ----------------------------------------------------------------------------
module rpvr_step #(
    parameter int OUTPUT_MAX_VOLTS = 1500,
    parameter int FRAC_BITS        = 16
) (
    input  rpvr_pkg::t_cfg      i_cfg,
    input  rpvr_pkg::t_state    i_state,
    input  rpvr_pkg::t_in_item  i_item,
    output rpvr_pkg::t_state    o_state,
    output rpvr_pkg::t_out_item o_item
);

    // gain term, integrator sum and drive sum widths
    localparam int GW = 65 - FRAC_BITS;
    localparam int IW = GW + 1;
    localparam int DW = GW + 2;

    // drive ceiling, saturated to the signed 32-bit range
    localparam longint DMAX_WIDE = longint'(OUTPUT_MAX_VOLTS) <<< FRAC_BITS;
    localparam logic signed [31:0] DRIVE_MAX =
        (DMAX_WIDE > 64'sh7fffffff) ? 32'sh7fffffff : 32'(DMAX_WIDE);
    localparam logic signed [31:0] DRIVE_MIN = 32'sh80000000;

    logic [31:0]        tgt_sum;
    logic [30:0]        tgt_new;
    logic signed [32:0] diff;
    logic signed [31:0] err_sat;
    logic signed [31:0] err;
    logic               err_ok;
    logic signed [64:0] iprod;
    logic signed [64:0] pprod;
    logic signed [GW-1:0] iterm;
    logic signed [GW-1:0] pterm;
    logic [47:0]        lim_wide;
    logic [30:0]        lim;
    logic signed [31:0] lim_s;
    logic signed [31:0] lim_neg;
    logic signed [IW-1:0] isum;
    logic signed [31:0] integ_clamped;
    logic signed [31:0] integ_used;
    logic [15:0]        fc_inc;
    logic signed [DW-1:0] dsum;
    logic signed [31:0] drive;
    logic [15:0]        sc_next;

    // target ramp, clamped at setpoint
    assign tgt_sum = {1'b0, i_state.target_voltage} + {1'b0, i_cfg.ramp_step};
    assign tgt_new = (tgt_sum > {1'b0, i_cfg.setpoint}) ? i_cfg.setpoint : tgt_sum[30:0];

    // error, saturated, zero on the first sample of a pulse
    assign diff = $signed({2'b00, tgt_new}) - $signed({i_item.measured_voltage[31],
                                                       i_item.measured_voltage});
    always_comb begin
        if (diff[32] != diff[31]) begin
            err_sat = diff[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            err_sat = diff[31:0];
        end
    end
    assign err    = (i_state.sample_count == 16'd0) ? 32'sd0 : err_sat;
    assign err_ok = err[31] || (err[30:0] <= i_cfg.allowed_error_abs);

    // gain products, floor of product over 2^FRAC_BITS
    assign iprod = err * $signed({1'b0, i_cfg.integ_gain});
    assign pprod = err * $signed({1'b0, i_cfg.prop_gain});
    assign iterm = iprod[64:FRAC_BITS];
    assign pterm = pprod[64:FRAC_BITS];

    // integrator limit in fixed point
    assign lim_wide = 48'(i_cfg.integ_limit) << FRAC_BITS;
    assign lim      = (lim_wide > 48'h7fffffff) ? 31'h7fffffff : lim_wide[30:0];
    assign lim_s    = {1'b0, lim};
    assign lim_neg  = -lim_s;

    // integrator update with symmetric clamp
    assign isum = IW'($signed(i_state.integrator)) + IW'(iterm);
    always_comb begin
        if (isum > IW'(lim_s)) begin
            integ_clamped = lim_s;
        end else if (isum < IW'(lim_neg)) begin
            integ_clamped = lim_neg;
        end else begin
            integ_clamped = isum[31:0];
        end
    end
    assign integ_used = err_ok ? integ_clamped : $signed(i_state.integrator);

    // drive sum, clamped above, saturated below
    assign dsum = DW'($signed({1'b0, tgt_new})) + DW'(pterm) + DW'(integ_used);
    always_comb begin
        if (dsum > DW'(DRIVE_MAX)) begin
            drive = DRIVE_MAX;
        end else if (dsum < DW'(DRIVE_MIN)) begin
            drive = DRIVE_MIN;
        end else begin
            drive = dsum[31:0];
        end
    end

    assign fc_inc  = i_state.following_count + 16'd1;
    assign sc_next = (i_state.sample_count != 16'hffff) ? i_state.sample_count + 16'd1
                                                        : i_state.sample_count;

    // next state and result selection
    always_comb begin
        o_state.target_voltage  = tgt_new;
        o_state.integrator      = integ_used;
        o_state.sample_count    = sc_next;
        o_state.following_count = i_state.following_count;
        o_item.drive_voltage    = drive;
        o_item.drive_valid      = 1'b1;
        o_item.pulse_done       = (sc_next >= i_cfg.pulse_points);
        o_item.following_fault  = 1'b0;

        if (i_item.func == rpvr_pkg::FUNC_STOP) begin
            o_state               = '0;
            o_item.drive_voltage  = '0;
            o_item.pulse_done     = 1'b0;
        end else if (err_ok) begin
            o_state.following_count = '0;
        end else if (i_cfg.fault_count_limit != 16'd0) begin
            o_state.following_count = fc_inc;
            if (fc_inc >= i_cfg.fault_count_limit) begin
                o_state.following_count = '0;
                o_state.sample_count    = i_state.sample_count;
                o_item.drive_voltage    = '0;
                o_item.drive_valid      = 1'b0;
                o_item.pulse_done       = 1'b0;
                o_item.following_fault  = 1'b1;
            end
        end
    end

endmodule

FILE: hdl/ramped_pi_voltage_regulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_pi_voltage_regulator
// PI voltage regulator with a ramped target, integrator clamp and
// following-error fault detection, one sample per item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_in_item  (func, measured_voltage)
//  out      output     o_out_valid / i_out_ready o_out_item (drive, valid, done, fault)
//  cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  one item per cycle sustained while the out channel is not stalled; an item
//  passes the input register, one combinational step and the result register
//  loop state updates as the item moves from the input register to the result
//  synchronous active-low reset clears loop state, configuration registers and valid flags
//  a stalled result holds while one more item waits in the input register
// ----------------------------------------------------------------------------
module ramped_pi_voltage_regulator #(
    parameter int OUTPUT_MAX_VOLTS = 1500,
    parameter int FRAC_BITS        = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rpvr_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rpvr_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [rpvr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rpvr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    rpvr_pkg::t_cfg      r_cfg;
    rpvr_pkg::t_state    r_state;
    rpvr_pkg::t_state    n_state;
    rpvr_pkg::t_in_item  r_in;
    logic                r_in_vld;
    rpvr_pkg::t_out_item r_out;
    rpvr_pkg::t_out_item n_out;
    logic                r_out_vld;
    logic                advance;

    // pipeline control
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpvr_pkg::CFG_SETPOINT:          r_cfg.setpoint          <= i_cfg_data[30:0];
                rpvr_pkg::CFG_RAMP_STEP:         r_cfg.ramp_step         <= i_cfg_data[30:0];
                rpvr_pkg::CFG_PROP_GAIN:         r_cfg.prop_gain         <= i_cfg_data;
                rpvr_pkg::CFG_INTEG_GAIN:        r_cfg.integ_gain        <= i_cfg_data;
                rpvr_pkg::CFG_ALLOWED_ERROR_ABS: r_cfg.allowed_error_abs <= i_cfg_data[30:0];
                rpvr_pkg::CFG_INTEG_LIMIT:       r_cfg.integ_limit       <= i_cfg_data[15:0];
                rpvr_pkg::CFG_FAULT_COUNT_LIMIT: r_cfg.fault_count_limit <= i_cfg_data[15:0];
                rpvr_pkg::CFG_PULSE_POINTS:      r_cfg.pulse_points      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // regulator step
    rpvr_step #(
        .OUTPUT_MAX_VOLTS (OUTPUT_MAX_VOLTS),
        .FRAC_BITS        (FRAC_BITS)
    ) u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_item  (n_out)
    );

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule
